// ===== src/tti_pkg.sv =====
// Shared types, codes and defaults for the triangle intersection core.
`timescale 1ns / 1ps
`default_nettype none
package tti_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // result codes
  localparam logic [1:0] OC_HIT  = 2'd0;
  localparam logic [1:0] OC_REF  = 2'd1;
  localparam logic [1:0] OC_TST  = 2'd2;
  localparam logic [1:0] OC_DISJ = 2'd3;

  // register indexes
  localparam logic REG_PLANE_TOL = 1'b0;
  localparam logic REG_OVL_TOL   = 1'b1;

  // datapath work phases
  typedef enum logic [2:0] {
    PH_N    = 3'd0,   // plane normal, cross product terms
    PH_D    = 3'd1,   // vertex distances to plane
    PH_DD   = 3'd2,   // line direction, axis pick
    PH_EDGE = 3'd3,   // edge crossings
    PH_VTX  = 3'd4    // vertices on plane
  } phase_t;

  typedef struct packed {
    logic       load_ref;
    logic       load_tst;
    logic       plane;
    phase_t     phase;
    logic [3:0] idx;
    logic       mul_start;
    logic       mul_step;
    logic       acc_apply;
    logic       chk;
    logic       div_start;
    logic       div_step;
    logic       wid_edge;
    logic       wid_vtx;
  } cmd_t;

  typedef struct packed {
    logic same_side;
    logic edge_act;
    logic disjoint;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/tti_dp.sv =====
// Datapath: vertex store, serial multiplier, accumulator, serial divider, intervals.
`timescale 1ns / 1ps
`default_nettype none
module tti_dp import tti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [9*COORD_BITS-1:0] crd,
  input  wire logic [31:0]             plane_tol,
  input  wire logic [15:0]             ovl_tol,
  input  wire cmd_t                    cmd,
  output sts_t                         sts
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NSW = 2*C + 2;
  localparam int DSW = 3*C + 4;
  localparam int MA  = 3*C + 3;
  localparam int MB  = (2*C + 1 > C + F) ? 2*C + 1 : C + F;
  localparam int PW  = MA + MB;
  localparam int AW  = PW + 2;
  localparam int DDW = 4*C + 3;
  localparam int QW  = C + F;
  localparam int DW  = 3*C + 4;
  localparam int EW  = C + F + 2;
  localparam int XW  = ((EW > 16) ? EW : 16) + 2;
  localparam int TW  = (DSW > 33) ? DSW : 33;

  logic signed [C-1:0]   ref_r [0:2][0:2];
  logic signed [C-1:0]   tst_r [0:2][0:2];
  logic signed [NSW-1:0] n_r   [0:1][0:2];
  logic signed [DSW-1:0] d_r   [0:1][0:2];
  logic signed [AW-1:0]  acc_r;
  logic [PW-1:0]         ma_r, prod_r;
  logic [MB-1:0]         mb_r;
  logic                  msgn_r;
  logic [DW-1:0]         rem_r, den_r;
  logic [QW-1:0]         nlo_r, quot_r;
  logic [1:0]            axis_r;
  logic [DDW-1:0]        best_r;
  logic signed [EW-1:0]  lo_r [0:1];
  logic signed [EW-1:0]  hi_r [0:1];
  logic                  iv_r [0:1];

  // index tables
  function automatic logic [1:0] cr_a(input logic [3:0] j);
    logic [1:0] r;
    r = 2'd0;
    case (j)
      4'd0: r = 2'd1; 4'd1: r = 2'd2; 4'd2: r = 2'd2;
      4'd3: r = 2'd0; 4'd4: r = 2'd0; 4'd5: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cr_b(input logic [3:0] j);
    logic [1:0] r;
    r = 2'd0;
    case (j)
      4'd0: r = 2'd2; 4'd1: r = 2'd1; 4'd2: r = 2'd0;
      4'd3: r = 2'd2; 4'd4: r = 2'd1; 4'd5: r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] div3(input logic [3:0] j);
    return (j >= 4'd6) ? 2'd2 : ((j >= 4'd3) ? 2'd1 : 2'd0);
  endfunction

  function automatic logic [1:0] mod3(input logic [3:0] j);
    logic [3:0] r;
    r = j - ((j >= 4'd6) ? 4'd6 : ((j >= 4'd3) ? 4'd3 : 4'd0));
    return r[1:0];
  endfunction

  logic [1:0] ca, cb, di, dk, ek, ei, ej;
  logic       eset;
  assign ca   = cr_a(cmd.idx);
  assign cb   = cr_b(cmd.idx);
  assign di   = div3(cmd.idx);
  assign dk   = mod3(cmd.idx);
  assign eset = (cmd.idx >= 4'd3);
  assign ek   = mod3(cmd.idx);
  assign ei   = (ek == 2'd2) ? 2'd1 : 2'd0;
  assign ej   = (ek == 2'd0) ? 2'd1 : 2'd2;

  // plane owner and the other triangle
  logic signed [C-1:0]   tv [0:2][0:2];
  logic signed [C-1:0]   qv [0:2][0:2];
  logic signed [C:0]     e1 [0:2];
  logic signed [C:0]     e2 [0:2];
  logic signed [C:0]     qd [0:2][0:2];
  logic signed [NSW-1:0] nsel [0:2];
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        tv[v][a] = cmd.plane ? tst_r[v][a] : ref_r[v][a];
        qv[v][a] = cmd.plane ? ref_r[v][a] : tst_r[v][a];
      end
    end
    for (int a = 0; a < 3; a++) begin
      e1[a]   = (C+1)'(tv[1][a]) - (C+1)'(tv[0][a]);
      e2[a]   = (C+1)'(tv[2][a]) - (C+1)'(tv[0][a]);
      nsel[a] = cmd.plane ? n_r[1][a] : n_r[0][a];
      for (int v = 0; v < 3; v++) qd[v][a] = (C+1)'(qv[v][a]) - (C+1)'(tv[0][a]);
    end
  end

  // projections onto the chosen axis and edge operands
  logic signed [C-1:0]   pe [0:2];
  logic signed [DSW-1:0] de [0:2];
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      pe[v] = eset ? tst_r[v][0] : ref_r[v][0];
      if (axis_r == 2'd1) pe[v] = eset ? tst_r[v][1] : ref_r[v][1];
      if (axis_r == 2'd2) pe[v] = eset ? tst_r[v][2] : ref_r[v][2];
      de[v] = eset ? d_r[0][v] : d_r[1][v];
    end
  end

  logic signed [C:0]     ediff;
  logic [C-1:0]          eabs;
  logic [MB-1:0]         span;
  logic signed [DSW-1:0] dvi, dvj, dni, dnj;
  logic [MA-1:0]         mag_i, mag_j;
  assign ediff = (C+1)'(pe[ej]) - (C+1)'(pe[ei]);
  assign eabs  = ediff[C] ? C'(-ediff) : C'(ediff);
  assign span  = MB'(eabs) << F;
  assign dvi   = de[ei];
  assign dvj   = de[ej];
  assign dni   = -dvi;
  assign dnj   = -dvj;
  assign mag_i = dvi[DSW-1] ? dni[MA-1:0] : dvi[MA-1:0];
  assign mag_j = dvj[DSW-1] ? dnj[MA-1:0] : dvj[MA-1:0];
  assign sts.edge_act = (dvi != '0) && (dvj != '0) && (dvi[DSW-1] != dvj[DSW-1]);

  // multiplier operands
  logic signed [MA:0] opa, opa_n;
  logic signed [MB:0] opb, opb_n;
  logic               osub;
  always_comb begin
    opa  = '0;
    opb  = '0;
    osub = 1'b0;
    unique case (cmd.phase)
      PH_N: begin
        opa  = (MA+1)'(e1[ca]);
        opb  = (MB+1)'(e2[cb]);
        osub = cmd.idx[0];
      end
      PH_D: begin
        opa = (MA+1)'(nsel[dk]);
        opb = (MB+1)'(qd[di][dk]);
      end
      PH_DD: begin
        opa  = (MA+1)'(n_r[0][ca]);
        opb  = (MB+1)'(n_r[1][cb]);
        osub = cmd.idx[0];
      end
      PH_EDGE: begin
        opa = {1'b0, mag_i};
        opb = {1'b0, span};
      end
      default: ;
    endcase
  end
  assign opa_n = -opa;
  assign opb_n = -opb;

  // accumulator update
  logic signed [AW-1:0] pz, sum, sum_n;
  logic [DDW-1:0]       smag;
  logic                 acc_clr;
  assign pz    = AW'(prod_r);
  assign sum   = acc_r + (msgn_r ? -pz : pz);
  assign sum_n = -sum;
  assign smag  = sum[AW-1] ? sum_n[DDW-1:0] : sum[DDW-1:0];
  // a finished term clears the accumulator for the next one
  assign acc_clr = ((cmd.phase == PH_N || cmd.phase == PH_DD) && cmd.idx[0]) ||
                   ((cmd.phase == PH_D) && (dk == 2'd2));

  // tolerance and same side check on the current plane
  logic signed [DSW-1:0] dz [0:2];
  always_comb begin
    logic signed [DSW-1:0] dc, dn;
    logic [TW-1:0]         m;
    for (int v = 0; v < 3; v++) begin
      dc = cmd.plane ? d_r[1][v] : d_r[0][v];
      dn = -dc;
      m  = dc[DSW-1] ? TW'(dn[DSW-2:0]) : TW'(dc[DSW-2:0]);
      dz[v] = (m < TW'(plane_tol)) ? '0 : dc;
    end
  end
  assign sts.same_side =
    ((dz[0] != '0) && !dz[0][DSW-1] && (dz[1] != '0) && !dz[1][DSW-1] &&
     (dz[2] != '0) && !dz[2][DSW-1]) ||
    (dz[0][DSW-1] && dz[1][DSW-1] && dz[2][DSW-1]);

  // divider step
  logic [PW-1:0] psh;
  logic [DW:0]   tr, trs;
  logic          ge;
  assign psh = prod_r >> QW;
  assign tr  = {rem_r, nlo_r[QW-1]};
  assign trs = tr - {1'b0, den_r};
  assign ge  = (tr >= {1'b0, den_r});

  // interval endpoint
  logic signed [EW-1:0] qx, ep;
  assign qx = EW'(quot_r);
  assign ep = (cmd.phase == PH_VTX) ? (EW'(pe[ek]) <<< F)
                                    : ((EW'(pe[ei]) <<< F) + (ediff[C] ? -qx : qx));

  // final overlap compare
  logic signed [XW-1:0] tolx, l1, h1, l2, h2;
  assign tolx = XW'(ovl_tol);
  assign l1   = XW'(lo_r[0]);
  assign h1   = XW'(hi_r[0]);
  assign l2   = XW'(lo_r[1]);
  assign h2   = XW'(hi_r[1]);
  assign sts.disjoint = !iv_r[0] || !iv_r[1] || (h1 < l2 - tolx) || (h2 < l1 - tolx);

  // reference triangle, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < 3; v++)
        for (int a = 0; a < 3; a++) ref_r[v][a] <= '0;
    end else if (cmd.load_ref) begin
      for (int v = 0; v < 3; v++)
        for (int a = 0; a < 3; a++) ref_r[v][a] <= crd[(3*v+a)*C +: C];
    end
  end

  // interval valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r[0] <= 1'b0;
      iv_r[1] <= 1'b0;
    end else if (cmd.load_tst) begin
      iv_r[0] <= 1'b0;
      iv_r[1] <= 1'b0;
    end else if (cmd.wid_edge || (cmd.wid_vtx && de[ek] == '0)) begin
      iv_r[eset] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_tst) begin
      for (int v = 0; v < 3; v++)
        for (int a = 0; a < 3; a++) tst_r[v][a] <= crd[(3*v+a)*C +: C];
      acc_r  <= '0;
      axis_r <= 2'd0;
      best_r <= '0;
    end
    // serial multiplier
    if (cmd.mul_start) begin
      ma_r   <= PW'(opa[MA] ? opa_n[MA-1:0] : opa[MA-1:0]);
      mb_r   <= opb[MB] ? opb_n[MB-1:0] : opb[MB-1:0];
      prod_r <= '0;
      msgn_r <= opa[MA] ^ opb[MB] ^ osub;
    end else if (cmd.mul_step) begin
      prod_r <= prod_r + (mb_r[0] ? ma_r : '0);
      ma_r   <= ma_r << 1;
      mb_r   <= mb_r >> 1;
    end
    // accumulate and store terms
    if (cmd.acc_apply) begin
      acc_r <= acc_clr ? '0 : sum;
      unique case (cmd.phase)
        PH_N: if (cmd.idx[0]) begin
          n_r[cmd.plane][cmd.idx[2:1]] <= NSW'(sum);
        end
        PH_D: if (dk == 2'd2) begin
          d_r[cmd.plane][di] <= DSW'(sum);
        end
        PH_DD: if (cmd.idx[0]) begin
          if (cmd.idx[2:1] == 2'd0 || smag > best_r) begin
            best_r <= smag;
            axis_r <= cmd.idx[2:1];
          end
        end
        default: ;
      endcase
    end
    // apply tolerance on the checked plane
    if (cmd.chk) begin
      for (int v = 0; v < 3; v++) d_r[cmd.plane][v] <= dz[v];
    end
    // serial divider
    if (cmd.div_start) begin
      den_r  <= DW'(mag_i) + DW'(mag_j);
      rem_r  <= psh[DW-1:0];
      nlo_r  <= prod_r[QW-1:0];
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? trs[DW-1:0] : tr[DW-1:0];
      nlo_r  <= nlo_r << 1;
      quot_r <= {quot_r[QW-2:0], ge};
    end
    // widen intervals
    if (cmd.wid_edge || (cmd.wid_vtx && de[ek] == '0)) begin
      if (!iv_r[eset] || ep < lo_r[eset]) lo_r[eset] <= ep;
      if (!iv_r[eset] || ep > hi_r[eset]) hi_r[eset] <= ep;
    end
  end

endmodule
`default_nettype wire

// ===== src/tti_ctrl.sv =====
// Controller: sequences products, plane checks, divisions and result.
`timescale 1ns / 1ps
`default_nettype none
module tti_ctrl import tti_pkg::*; #(
  parameter int MUL_ITER = 33,
  parameter int DIV_ITER = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_op,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [1:0]      out_code,
  output cmd_t            cmd,
  input  wire sts_t       sts
);

  localparam int ITMAX = (MUL_ITER > DIV_ITER) ? MUL_ITER : DIV_ITER;
  localparam int ITW   = $clog2(ITMAX + 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MST  = 12'b000000000010,
    S_MUL  = 12'b000000000100,
    S_ACC  = 12'b000000001000,
    S_CHK  = 12'b000000010000,
    S_ESEL = 12'b000000100000,
    S_DST  = 12'b000001000000,
    S_DIV  = 12'b000010000000,
    S_WID  = 12'b000100000000,
    S_VTX  = 12'b001000000000,
    S_CMP  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t       state_r, state_nxt;
  phase_t       phase_r, phase_nxt;
  logic         plane_r, plane_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic [ITW-1:0] cnt_r, cnt_nxt;
  logic [1:0]   code_r, code_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [1:0]   out_code_r, out_code_nxt;
  logic         acc_in;

  assign in_tready  = (state_r == S_IDLE);
  assign acc_in     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_code   = out_code_r;

  // commands
  always_comb begin
    cmd           = '0;
    cmd.plane     = plane_r;
    cmd.phase     = phase_r;
    cmd.idx       = idx_r;
    cmd.load_ref  = acc_in && !in_op;
    cmd.load_tst  = acc_in && in_op;
    cmd.mul_start = (state_r == S_MST);
    cmd.mul_step  = (state_r == S_MUL);
    cmd.acc_apply = (state_r == S_ACC);
    cmd.chk       = (state_r == S_CHK);
    cmd.div_start = (state_r == S_DST);
    cmd.div_step  = (state_r == S_DIV);
    cmd.wid_edge  = (state_r == S_WID);
    cmd.wid_vtx   = (state_r == S_VTX);
  end

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    plane_nxt     = plane_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_code_nxt  = out_code_r;
    unique case (state_r)
      S_IDLE: if (acc_in && in_op) begin
        phase_nxt = PH_N;
        plane_nxt = 1'b0;
        idx_nxt   = 4'd0;
        state_nxt = S_MST;
      end
      S_MST: begin
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ITW'(MUL_ITER - 1))
          state_nxt = (phase_r == PH_EDGE) ? S_DST : S_ACC;
      end
      S_ACC: begin
        idx_nxt   = idx_r + 4'd1;
        state_nxt = S_MST;
        unique case (phase_r)
          PH_N: if (idx_r == 4'd5) begin
            phase_nxt = PH_D;
            idx_nxt   = 4'd0;
          end
          PH_D: if (idx_r == 4'd8) state_nxt = S_CHK;
          PH_DD: if (idx_r == 4'd5) begin
            phase_nxt = PH_EDGE;
            idx_nxt   = 4'd0;
            state_nxt = S_ESEL;
          end
          default: ;
        endcase
      end
      S_CHK: begin
        idx_nxt   = 4'd0;
        state_nxt = S_MST;
        if (sts.same_side) begin
          code_nxt  = plane_r ? OC_TST : OC_REF;
          state_nxt = S_OUT;
        end else if (!plane_r) begin
          plane_nxt = 1'b1;
          phase_nxt = PH_N;
        end else begin
          phase_nxt = PH_DD;
        end
      end
      S_ESEL: begin
        if (sts.edge_act) state_nxt = S_MST;
        else if (idx_r == 4'd5) begin
          phase_nxt = PH_VTX;
          idx_nxt   = 4'd0;
          state_nxt = S_VTX;
        end else idx_nxt = idx_r + 4'd1;
      end
      S_DST: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ITW'(DIV_ITER - 1)) state_nxt = S_WID;
      end
      S_WID: begin
        if (idx_r == 4'd5) begin
          phase_nxt = PH_VTX;
          idx_nxt   = 4'd0;
          state_nxt = S_VTX;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_ESEL;
        end
      end
      S_VTX: begin
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd5) state_nxt = S_CMP;
      end
      S_CMP: begin
        code_nxt  = sts.disjoint ? OC_DISJ : OC_HIT;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_valid_r || out_tready) begin
        out_valid_nxt = 1'b1;
        out_code_nxt  = code_r;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_N;
      plane_r     <= 1'b0;
      idx_r       <= 4'd0;
      cnt_r       <= '0;
      code_r      <= OC_HIT;
      out_valid_r <= 1'b0;
      out_code_r  <= OC_HIT;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      plane_r     <= plane_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
      out_code_r  <= out_code_nxt;
    end
  end

  // a test request always starts work
  a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op) |=> (state_r == S_MST))
    else $error("test request did not start the sequence");

  // a result is only posted from the result state
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result posted outside result state");

  // multiplier count stays in range
  a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r < ITW'(MUL_ITER)))
    else $error("multiplier count overrun");

  // divisions only happen for edge crossings
  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_DST) |-> (phase_r == PH_EDGE))
    else $error("division outside edge phase");

endmodule
`default_nettype wire

// ===== src/triangle_triangle_intersect_core.sv =====
// Top level: stream ports, register port, controller and datapath.
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   tdata: vertex coords, tuser: op
//  out_     out  out_tvalid / out_tready tdata: hit, outcome
//  cfg_     in   APB psel/penable        plane_tolerance @0, overlap_tolerance @4
//
// A load request only stores the reference triangle. A test request runs on one
// shared bit-serial multiplier (MB = max(2C+1, C+F) bits) and one restoring divider
// (used after a product for each edge crossing): 15 products per plane check, 6 for
// the line direction and at most four divisions.
// Synchronous active-low reset clears the reference triangle, the interval flags
// and the control and tolerance registers.
// A finished result waits in the output register; the next request is taken
// meanwhile, and a second result stalls only until the first is taken.
`timescale 1ns / 1ps
`default_nettype none
module triangle_triangle_intersect_core import tti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
  input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic [0:0] in_tuser,   // op
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic [7:0]      out_tdata,  // hit, outcome[1:0]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MB = (2*C + 1 > C + F) ? 2*C + 1 : C + F;
  localparam int QW = C + F;

  logic [31:0] plane_tol_r;
  logic [15:0] ovl_tol_r;
  logic        wr;
  cmd_t        cmd;
  sts_t        sts;
  logic [1:0]  code;

  // register port
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_OVL_TOL) ? {16'd0, ovl_tol_r} : plane_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_tol_r <= '0;
      ovl_tol_r   <= '0;
    end else if (wr) begin
      if (cfg_paddr[2] == REG_PLANE_TOL) plane_tol_r <= cfg_pwdata;
      else ovl_tol_r <= cfg_pwdata[15:0];
    end
  end

  assign out_tdata = {5'd0, code, code == OC_HIT};

  tti_ctrl #(
    .MUL_ITER(MB),
    .DIV_ITER(QW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser[0]),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_code  (code),
    .cmd       (cmd),
    .sts       (sts)
  );

  tti_dp #(
    .COORD_BITS(C),
    .FRAC_BITS (F)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .crd      (in_tdata[9*C-1:0]),
    .plane_tol(plane_tol_r),
    .ovl_tol  (ovl_tol_r),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire
